>>> src/awwe_pkg.sv
// awwe_pkg: shared constants, beat types and the prefix digit weights
// for the rolling amino word encoder. No dependencies.
`timescale 1ns / 1ps
package awwe_pkg;

    localparam int unsigned PREFIX_LEN    = 6;
    localparam int unsigned SUFFIX_LEN    = 12;
    localparam int unsigned WORD_LEN      = PREFIX_LEN + SUFFIX_LEN;
    localparam int unsigned ALPHABET_SIZE = 20;
    localparam int unsigned AMINO_BITS    = 5;
    localparam int unsigned POSITION_BITS = 32;
    localparam int unsigned RUN_BITS      = $clog2(WORD_LEN + 1);

    localparam int unsigned CODE_W  = 5;
    localparam int unsigned START_W = 32;
    localparam int unsigned PFX_W   = 26;
    localparam int unsigned SFX_W   = 60;

    typedef logic [AMINO_BITS-1:0]    t_amino;
    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [RUN_BITS-1:0]      t_run;

    typedef struct packed {
        logic [CODE_W-1:0] amino_code;
        logic              invalid;
        logic              new_sequence;
    } t_in_beat;

    typedef struct packed {
        logic [START_W-1:0] word_start;
        logic [PFX_W-1:0]   fwd_prefix;
        logic [SFX_W-1:0]   fwd_suffix;
        logic [PFX_W-1:0]   rev_prefix;
        logic [SFX_W-1:0]   rev_suffix;
    } t_out_beat;

    // control handed to every cell of the history chain
    typedef struct packed {
        logic clr;
        logic shift;
    } t_cell_ctl;

    // ALPHABET_SIZE ** exp, cut to the prefix width
    function automatic logic [PFX_W-1:0] digit_weight(input int unsigned exp);
        logic [63:0] v;
        v = 64'd1;
        for (int unsigned k = 0; k < exp; k++) begin
            v = v * 64'(ALPHABET_SIZE);
        end
        return v[PFX_W-1:0];
    endfunction

endpackage

>>> src/amino_word_window_encoder_top.sv
// amino_word_window_encoder_top: rolling amino word encoder, chain of
// history cells plus control and output register.
// Depends on awwe_pkg, awwe_cell, awwe_ctrl, awwe_pack.
//
//   channel | ports                                    | dir
//   in      | i_in_valid, o_in_stall, i_in_beat        | beats in
//   out     | o_out_valid, i_out_stall, o_out_beat     | beats out
//
// One input beat per cycle unless stalled; a word appears in the cycle
// after the beat that completes it, from the output register. o_in_stall
// is high only while a held result is stalled. Synchronous active-low
// reset clears the history chain, run count, position and output valid.
`timescale 1ns / 1ps
module amino_word_window_encoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  awwe_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output awwe_pkg::t_out_beat o_out_beat
);
    import awwe_pkg::*;

    logic                accept;
    logic                busy;
    t_cell_ctl           ctl;
    logic                emit;
    logic [START_W-1:0]  word_start;
    t_amino              din   [WORD_LEN];
    t_amino              carry [WORD_LEN];
    t_amino              hist  [WORD_LEN];

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    awwe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_beat       (i_in_beat),
        .o_ctl        (ctl),
        .o_emit       (emit),
        .o_word_start (word_start)
    );

    assign din[0] = AMINO_BITS'(i_in_beat.amino_code);

    for (genvar k = 0; k < WORD_LEN; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign din[k] = carry[k-1];
        end
        awwe_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_din   (din[k]),
            .o_carry (carry[k]),
            .o_next  (hist[k])
        );
    end

    awwe_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_emit       (emit),
        .i_word_start (word_start),
        .i_hist       (hist),
        .i_out_stall  (i_out_stall),
        .o_busy       (busy),
        .o_out_valid  (o_out_valid),
        .o_out_beat   (o_out_beat)
    );

endmodule

>>> src/awwe_cell.sv
// awwe_cell: one amino slot of the history chain.
// Depends on awwe_pkg.
`timescale 1ns / 1ps
module awwe_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  awwe_pkg::t_cell_ctl i_ctl,
    input  awwe_pkg::t_amino    i_din,
    output awwe_pkg::t_amino    o_carry,
    output awwe_pkg::t_amino    o_next
);
    import awwe_pkg::*;

    t_amino r_q;
    t_amino n_q;

    always_comb begin
        if (i_ctl.shift) begin
            n_q = i_din;
        end else if (i_ctl.clr) begin
            n_q = '0;
        end else begin
            n_q = r_q;
        end
    end

    // a cleared slot hands zero to its neighbor in the same beat
    assign o_carry = i_ctl.clr ? '0 : r_q;
    assign o_next  = n_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

endmodule

>>> src/awwe_ctrl.sv
// awwe_ctrl: position counter, valid run counter and word emit decision.
// Depends on awwe_pkg.
`timescale 1ns / 1ps
module awwe_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  awwe_pkg::t_in_beat          i_beat,
    output awwe_pkg::t_cell_ctl         o_ctl,
    output logic                        o_emit,
    output logic [awwe_pkg::START_W-1:0] o_word_start
);
    import awwe_pkg::*;

    t_pos r_pos;
    t_pos n_pos;
    t_run r_run;
    t_run n_run;
    t_pos pos_cur;
    t_run run_base;
    logic clr;
    logic bad;

    always_comb begin
        clr      = i_accept && i_beat.new_sequence;
        bad      = i_beat.invalid || (i_beat.amino_code >= CODE_W'(ALPHABET_SIZE));
        pos_cur  = clr ? '0 : r_pos;
        run_base = clr ? '0 : r_run;
        n_pos    = r_pos;
        n_run    = r_run;
        if (i_accept) begin
            n_pos = pos_cur + POSITION_BITS'(1);
            if (bad) begin
                n_run = '0;
            end else if (run_base < RUN_BITS'(WORD_LEN)) begin
                n_run = run_base + RUN_BITS'(1);
            end else begin
                n_run = run_base;
            end
        end
        o_ctl.clr    = clr;
        o_ctl.shift  = i_accept && !bad;
        o_emit       = i_accept && !bad && (n_run == RUN_BITS'(WORD_LEN));
        o_word_start = START_W'(pos_cur - POSITION_BITS'(WORD_LEN - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_run <= '0;
        end else begin
            r_pos <= n_pos;
            r_run <= n_run;
        end
    end

endmodule

>>> src/awwe_pack.sv
// awwe_pack: encodes the next chain contents into prefixes and suffixes
// and holds the result beat in the output register. Depends on awwe_pkg.
`timescale 1ns / 1ps
module awwe_pack (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_emit,
    input  logic [awwe_pkg::START_W-1:0] i_word_start,
    input  awwe_pkg::t_amino             i_hist [awwe_pkg::WORD_LEN],
    input  logic                         i_out_stall,
    output logic                         o_busy,
    output logic                         o_out_valid,
    output awwe_pkg::t_out_beat          o_out_beat
);
    import awwe_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_beat r_beat;
    t_out_beat beat;
    logic      load;

    // i_hist[0] is the newest amino
    always_comb begin
        beat            = '0;
        beat.word_start = i_word_start;
        for (int unsigned i = 0; i < PREFIX_LEN; i++) begin
            beat.fwd_prefix = beat.fwd_prefix
                + PFX_W'(PFX_W'(i_hist[SUFFIX_LEN + i]) * digit_weight(i));
            beat.rev_prefix = beat.rev_prefix
                + PFX_W'(PFX_W'(i_hist[PREFIX_LEN - 1 - i]) * digit_weight(i));
        end
        for (int unsigned j = 0; j < SUFFIX_LEN; j++) begin
            beat.fwd_suffix[j*AMINO_BITS +: AMINO_BITS] = i_hist[j];
            beat.rev_suffix[j*AMINO_BITS +: AMINO_BITS] = i_hist[WORD_LEN - 1 - j];
        end
    end

    always_comb begin
        load    = !(r_valid && i_out_stall);
        n_valid = load ? i_emit : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_emit) begin
            r_beat <= beat;
        end
    end

    assign o_busy      = !load;
    assign o_out_valid = r_valid;
    assign o_out_beat  = r_beat;

endmodule

>>> tb/awwe_word_checker.sv
// awwe_word_checker: watches both channels of the amino word encoder, predicts
// every word from the accepted input beats and compares the words that come out.
// Depends on awwe_pkg.
`timescale 1ns / 1ps
module awwe_word_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  awwe_pkg::t_in_beat  i_in_beat,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  awwe_pkg::t_out_beat i_out_beat,
    output int                  o_errors,
    output int                  o_words,
    output int                  o_pending
);
    import awwe_pkg::*;

    localparam longint unsigned PFX_SPAN  = ALPHABET_SIZE ** PREFIX_LEN;
    localparam int unsigned     TOP_SHIFT = AMINO_BITS * (SUFFIX_LEN - 1);
    localparam int              MAX_REPORTS = 10;

    logic [PFX_W-1:0] fwd_pfx;
    logic [SFX_W-1:0] fwd_sfx;
    logic [PFX_W-1:0] rev_pfx;
    logic [SFX_W-1:0] rev_sfx;
    int unsigned      run_len;
    t_pos             seq_pos;

    t_out_beat words_due[$];
    int        errors;
    int        words;

    task automatic clear_window();
        fwd_pfx = '0;
        fwd_sfx = '0;
        rev_pfx = '0;
        rev_sfx = '0;
        run_len = 0;
        seq_pos = '0;
    endtask

    task automatic advance_window(input t_in_beat b);
        logic [63:0] code;
        logic [63:0] carry;
        logic [63:0] acc;
        t_pos        here;
        t_out_beat   w;
        logic        bad;
        code = 64'(b.amino_code);
        bad  = b.invalid || (code >= ALPHABET_SIZE);
        if (b.new_sequence) begin
            clear_window();
        end
        here    = seq_pos;
        seq_pos = here + 1'b1;
        if (bad) begin
            run_len = 0;
            return;
        end
        // forward: oldest suffix amino shifts into the prefix
        carry   = 64'(fwd_sfx >> TOP_SHIFT) & 64'((1 << AMINO_BITS) - 1);
        acc     = (64'(fwd_pfx) * ALPHABET_SIZE) % PFX_SPAN;
        acc     = (acc + carry) % PFX_SPAN;
        fwd_pfx = acc[PFX_W-1:0];
        fwd_sfx = {fwd_sfx[SFX_W-AMINO_BITS-1:0], b.amino_code[AMINO_BITS-1:0]};
        // reverse: lowest prefix digit drops into the suffix top
        carry   = 64'(rev_pfx) % ALPHABET_SIZE;
        acc     = (64'(rev_pfx) / ALPHABET_SIZE + code * (PFX_SPAN / ALPHABET_SIZE)) % PFX_SPAN;
        rev_pfx = acc[PFX_W-1:0];
        rev_sfx = {carry[AMINO_BITS-1:0], rev_sfx[SFX_W-1:AMINO_BITS]};
        if (run_len < WORD_LEN) begin
            run_len++;
        end
        if (run_len == WORD_LEN) begin
            w.word_start = here + 1 - WORD_LEN;
            w.fwd_prefix = fwd_pfx;
            w.fwd_suffix = fwd_sfx;
            w.rev_prefix = rev_pfx;
            w.rev_suffix = rev_sfx;
            words_due.push_back(w);
        end
    endtask

    task automatic check_word(input t_out_beat got);
        t_out_beat want;
        if (words_due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t: unexpected word start=%h fp=%h fs=%h rp=%h rs=%h", $time,
                         got.word_start, got.fwd_prefix, got.fwd_suffix,
                         got.rev_prefix, got.rev_suffix);
            end
            return;
        end
        want = words_due.pop_front();
        words++;
        if (got.word_start !== want.word_start || got.fwd_prefix !== want.fwd_prefix ||
            got.fwd_suffix !== want.fwd_suffix || got.rev_prefix !== want.rev_prefix ||
            got.rev_suffix !== want.rev_suffix) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t: word mismatch exp start=%h fp=%h fs=%h rp=%h rs=%h", $time,
                         want.word_start, want.fwd_prefix, want.fwd_suffix,
                         want.rev_prefix, want.rev_suffix);
                $display("%0t:               got start=%h fp=%h fs=%h rp=%h rs=%h", $time,
                         got.word_start, got.fwd_prefix, got.fwd_suffix,
                         got.rev_prefix, got.rev_suffix);
            end
        end
    endtask

    initial begin
        errors = 0;
        words  = 0;
        clear_window();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_window();
            words_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_word(i_out_beat);
            end
            if (i_in_valid && !i_in_stall) begin
                advance_window(i_in_beat);
            end
        end
        o_errors  <= errors;
        o_words   <= words;
        o_pending <= words_due.size();
    end

endmodule

>>> tb/tb_amino_word_window_encoder_top.sv
// tb_amino_word_window_encoder_top: drives amino beats into the word encoder
// with random gaps and output stalls, and reports the verdict.
// Depends on awwe_pkg, amino_word_window_encoder_top, awwe_word_checker.
`timescale 1ns / 1ps
module tb_amino_word_window_encoder_top;
    import awwe_pkg::*;

    localparam int DIRECTED_BEATS = 25;
    localparam int RANDOM_BEATS   = 850;
    localparam int HOLD_CYCLES    = 250;
    localparam int DRAIN_CYCLES   = 10;
    localparam int LIMIT_CYCLES   = 400000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_beat   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_beat;

    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    int chk_errors;
    int chk_words;
    int chk_pending;
    int beats_sent;
    int steady_left;
    int records;
    int cycle_count;

    amino_word_window_encoder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    awwe_word_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_beat  (o_out_beat),
        .o_errors    (chk_errors),
        .o_words     (chk_words),
        .o_pending   (chk_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_amino_word_window_encoder_top failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_beat mk_beat(input int code, input bit inv, input bit restart);
        t_in_beat b;
        b.amino_code   = code[CODE_W-1:0];
        b.invalid      = inv;
        b.new_sequence = restart;
        return b;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_beat(input t_in_beat b);
        int gap;
        if (steady_left > 0) begin
            gap = 0;
            steady_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 39) == 0) begin
                steady_left = $urandom_range(20, 60);
            end
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_record(input int len, input bit noisy);
        t_in_beat b;
        int       r;
        records++;
        for (int k = 0; k < len; k++) begin
            if (k == 0) begin
                b.new_sequence = ($urandom_range(0, 9) != 0);
            end else begin
                b.new_sequence = ($urandom_range(0, 149) == 0);
            end
            r = $urandom_range(0, 99);
            if (noisy) begin
                b.amino_code = CODE_W'($urandom_range(0, 31));
                b.invalid    = 1'($urandom_range(0, 1));
            end else if (r < 1) begin
                b.amino_code = CODE_W'($urandom_range(0, 31));
                b.invalid    = 1'b1;
            end else if (r < 2) begin
                b.amino_code = CODE_W'($urandom_range(ALPHABET_SIZE, 31));
                b.invalid    = 1'b0;
            end else begin
                b.amino_code = CODE_W'($urandom_range(0, ALPHABET_SIZE - 1));
                b.invalid    = 1'b0;
            end
            send_beat(b);
        end
    endtask

    // receiver: random stalls, quiet stretches, and one long hold-off
    initial begin
        int open_left;
        int shut_left;
        open_left = 0;
        shut_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_done   <= 1'b1;
            end else begin
                if (open_left == 0 && shut_left == 0) begin
                    if ($urandom_range(0, 9) == 0) begin
                        open_left = $urandom_range(40, 120);
                    end else begin
                        open_left = $urandom_range(1, 10);
                        shut_left = pick_gap();
                    end
                end
                if (shut_left > 0) begin
                    i_out_stall <= 1'b1;
                    shut_left--;
                end else begin
                    i_out_stall <= 1'b0;
                    open_left--;
                end
            end
        end
    end

    initial begin
        bit burst_done;
        int rec_len;
        beats_sent  = 0;
        steady_left = 0;
        records     = 0;
        cycle_count = 0;
        burst_done  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full word with alphabet extremes, then breaks of every kind
        send_beat(mk_beat(ALPHABET_SIZE - 1, 1'b0, 1'b1));
        for (int k = 1; k < WORD_LEN; k++) begin
            send_beat(mk_beat((k * 7) % ALPHABET_SIZE, 1'b0, 1'b0));
        end
        send_beat(mk_beat(0, 1'b0, 1'b0));
        send_beat(mk_beat(ALPHABET_SIZE - 1, 1'b0, 1'b0));
        send_beat(mk_beat(ALPHABET_SIZE, 1'b0, 1'b0));
        send_beat(mk_beat(31, 1'b0, 1'b0));
        send_beat(mk_beat(7, 1'b1, 1'b0));
        send_beat(mk_beat(31, 1'b1, 1'b1));
        send_beat(mk_beat(0, 1'b0, 1'b1));

        while (beats_sent < DIRECTED_BEATS + RANDOM_BEATS) begin
            if (!burst_done && beats_sent >= 300) begin
                burst_done  = 1'b1;
                hold_req    <= 1'b1;
                steady_left = 100;
                send_record(100, 1'b0);
            end else begin
                rec_len = $urandom_range(20, 90);
                if (rec_len > DIRECTED_BEATS + RANDOM_BEATS - beats_sent) begin
                    rec_len = DIRECTED_BEATS + RANDOM_BEATS - beats_sent;
                end
                send_record(rec_len, $urandom_range(0, 19) == 0);
            end
        end
        i_in_valid <= 1'b0;

        while (chk_pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("run covered %0d input beats in %0d records, %0d words compared",
                 beats_sent, records, chk_words);
        $display("including one %0d-cycle output hold-off under back-to-back input",
                 HOLD_CYCLES);
        if (chk_errors == 0) begin
            $display("tb_amino_word_window_encoder_top passed");
        end else begin
            $display("tb_amino_word_window_encoder_top failed");
        end
        $finish;
    end

endmodule
